// ----- design/bde_pkg.sv -----
// Shared types and constants for the button debouncer with edge detection.
`default_nettype none

package bde_pkg;

   // Widths fixed by the word format.
   localparam int FIELD_BITS = 4;
   localparam int TIME_BITS  = 32;
   localparam int DELAY_BITS = 16;
   localparam int ADDR_BITS  = 3;
   localparam int DATA_BITS  = 32;

   typedef logic [FIELD_BITS-1:0] mask_type;
   typedef logic [TIME_BITS-1:0]  stamp_type;
   typedef logic [DELAY_BITS-1:0] delay_type;

   // Reset value of both delay registers.
   localparam delay_type DEFAULT_DELAY_MS = 16'd50;

   // Register indexes, decoded from paddr[2].
   localparam logic REG_DEBOUNCE = 1'b0;
   localparam logic REG_RESPONSE = 1'b1;

   // Register values handed from the register block to the datapath.
   typedef struct packed {
      delay_type debounce_ms;
      delay_type response_interval_ms;
   } csr_type;

   // Stable bit of one channel before and after the current poll.
   typedef struct packed {
      logic stable_now;
      logic stable_next;
   } chan_status_type;

endpackage : bde_pkg

`default_nettype wire

// ----- design/bde_channels_if.sv -----
// Handshake interfaces for the poll channel and the result channel.
`default_nettype none

interface bde_req_if;
   import bde_pkg::*;

   logic      valid;
   logic      ready;
   mask_type  raw_levels;
   stamp_type now_ms;

   modport source (output valid, output raw_levels, output now_ms, input ready);
   modport sink   (input valid, input raw_levels, input now_ms, output ready);
endinterface : bde_req_if

interface bde_rsp_if;
   import bde_pkg::*;

   logic     valid;
   logic     ready;
   mask_type stable_mask;
   mask_type pressed_mask;
   mask_type held_mask;
   mask_type released_mask;
   logic     respond_flag;
   mask_type fire_mask;

   modport source (output valid, output stable_mask, output pressed_mask,
                   output held_mask, output released_mask, output respond_flag,
                   output fire_mask, input ready);
   modport sink   (input valid, input stable_mask, input pressed_mask,
                   input held_mask, input released_mask, input respond_flag,
                   input fire_mask, output ready);
endinterface : bde_rsp_if

`default_nettype wire

// ----- design/button_debounce_edge_detector_top.sv -----
// Top level of the button debouncer with edge detection and response pacing.
//
// The block takes one poll word per clock while the sink does not hold a
// result, and returns one result word per poll, in order. A poll is captured
// in an input register. When the output register is free or being taken, the
// per-button debounce cells and the response pacer update and the result
// lands in an output register. The rate of one word per cycle is set by each
// cell's stable bit, pending flag and timestamp being updated as a poll
// leaves the input register, ready for the next poll to read. While the
// result register is held by the sink, one further poll waits in the input
// register; then req_if.ready drops.
// Only the first min(NUM_CHANNELS, 4) buttons are present; the mask bits of
// the others read as zero. Registers: debounce_ms at byte address 0 and
// response_interval_ms at byte address 4, both 16 bits, reset to 50.
`default_nettype none

module button_debounce_edge_detector_top #(
   parameter int NUM_CHANNELS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   bde_req_if.sink                       req_if,
   bde_rsp_if.source                     rsp_if,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bde_pkg::ADDR_BITS-1:0] paddr,
   input  logic [bde_pkg::DATA_BITS-1:0] pwdata,
   output logic [bde_pkg::DATA_BITS-1:0] prdata,
   output logic                          pready
);
   import bde_pkg::*;

   localparam int LIVE_CHANNELS = (NUM_CHANNELS < FIELD_BITS) ? NUM_CHANNELS : FIELD_BITS;

   csr_type         csr;
   chan_status_type status [FIELD_BITS];

   logic      in_valid_ff, in_valid_in;
   mask_type  in_levels_ff;
   stamp_type in_now_ff;
   logic      out_valid_ff, out_valid_in;
   logic      advance;
   logic      take;
   logic      accept;

   mask_type  stable_now;
   mask_type  stable_next;
   mask_type  pressed;
   stamp_type last_resp_ff, last_resp_in;
   stamp_type resp_elapsed;
   logic      respond;

   mask_type  stable_ff;
   mask_type  pressed_ff;
   mask_type  held_ff;
   mask_type  released_ff;
   logic      respond_ff;
   mask_type  fire_ff;

   // Register block.
   bde_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .csr     (csr)
   );

   // Handshake: the input register moves on whenever the result register is free.
   assign advance      = !out_valid_ff || rsp_if.ready;
   assign take         = in_valid_ff && advance;
   assign req_if.ready = !in_valid_ff || advance;
   assign accept       = req_if.valid && req_if.ready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = take || (out_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_levels_ff <= req_if.raw_levels;
         in_now_ff    <= req_if.now_ms;
      end
   end

   // One debounce cell per present button; absent buttons read as released.
   for (genvar i = 0; i < FIELD_BITS; i++) begin : g_chan
      if (i < LIVE_CHANNELS) begin : g_live
         bde_chan u_chan (
            .clock       (clock),
            .reset       (reset),
            .enable      (take),
            .sample      (!in_levels_ff[i]),
            .now_ms      (in_now_ff),
            .debounce_ms (csr.debounce_ms),
            .status      (status[i])
         );
      end else begin : g_absent
         assign status[i] = '0;
      end
   end

   always_comb begin
      for (int i = 0; i < FIELD_BITS; i++) begin
         stable_now[i]  = status[i].stable_now;
         stable_next[i] = status[i].stable_next;
      end
   end

   assign pressed = stable_next & ~stable_now;

   // Response pacer: the window opens once the interval has elapsed.
   assign resp_elapsed = in_now_ff - last_resp_ff;
   assign respond      = resp_elapsed >= {{(TIME_BITS-DELAY_BITS){1'b0}},
                                          csr.response_interval_ms};
   assign last_resp_in = respond ? in_now_ff : last_resp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_resp_ff <= '0;
      end else if (take) begin
         last_resp_ff <= last_resp_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (take) begin
         stable_ff   <= stable_next;
         pressed_ff  <= pressed;
         held_ff     <= stable_next & stable_now;
         released_ff <= ~stable_next & stable_now;
         respond_ff  <= respond;
         fire_ff     <= respond ? pressed : '0;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.stable_mask   = stable_ff;
   assign rsp_if.pressed_mask  = pressed_ff;
   assign rsp_if.held_mask     = held_ff;
   assign rsp_if.released_mask = released_ff;
   assign rsp_if.respond_flag  = respond_ff;
   assign rsp_if.fire_mask     = fire_ff;

   // A poll leaving the input register always produces a result in the next cycle.
   a_take_gives_result: assert property (@(posedge clock) disable iff (reset)
      take |=> out_valid_ff)
      else $error("poll taken without a result following");

   // The stable mask of a result is exactly the pressed and held buttons.
   a_stable_split: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (stable_ff == (pressed_ff | held_ff)))
      else $error("stable mask disagrees with pressed and held masks");

   // Fire events only come out of an open response window.
   a_fire_in_window: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !respond_ff) |-> (fire_ff == '0))
      else $error("fire mask set outside a response window");

   // The pacer only moves its timestamp when a poll is processed.
   a_pacer_quiet: assert property (@(posedge clock) disable iff (reset)
      (!take && !$past(reset)) |=> (last_resp_ff == $past(last_resp_ff)))
      else $error("response timestamp changed without a poll");

endmodule : button_debounce_edge_detector_top

`default_nettype wire

// ----- design/bde_csr.sv -----
// APB-style register block holding the debounce delay and the response interval.
`default_nettype none

module bde_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bde_pkg::ADDR_BITS-1:0] paddr,
   input  logic [bde_pkg::DATA_BITS-1:0] pwdata,
   output logic [bde_pkg::DATA_BITS-1:0] prdata,
   output logic                         pready,
   output bde_pkg::csr_type             csr
);
   import bde_pkg::*;

   delay_type debounce_ff, debounce_in;
   delay_type interval_ff, interval_in;
   logic      write_en;
   logic      reg_index;

   assign pready    = 1'b1;
   assign write_en  = psel && penable && pwrite;
   assign reg_index = paddr[2];

   // Register writes complete in the access phase.
   always_comb begin
      debounce_in = debounce_ff;
      interval_in = interval_ff;
      if (write_en) begin
         unique case (reg_index)
            REG_DEBOUNCE: debounce_in = pwdata[DELAY_BITS-1:0];
            REG_RESPONSE: interval_in = pwdata[DELAY_BITS-1:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEFAULT_DELAY_MS;
         interval_ff <= DEFAULT_DELAY_MS;
      end else begin
         debounce_ff <= debounce_in;
         interval_ff <= interval_in;
      end
   end

   // Read-back of the addressed register.
   always_comb begin
      unique case (reg_index)
         REG_DEBOUNCE: prdata = {{(DATA_BITS-DELAY_BITS){1'b0}}, debounce_ff};
         REG_RESPONSE: prdata = {{(DATA_BITS-DELAY_BITS){1'b0}}, interval_ff};
         default:      prdata = '0;
      endcase
   end

   assign csr.debounce_ms          = debounce_ff;
   assign csr.response_interval_ms = interval_ff;

endmodule : bde_csr

`default_nettype wire

// ----- design/bde_chan.sv -----
// Debounce cell for one button: stable bit, pending flag and change timestamp.
`default_nettype none

module bde_chan (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     sample,
   input  bde_pkg::stamp_type       now_ms,
   input  bde_pkg::delay_type       debounce_ms,
   output bde_pkg::chan_status_type status
);
   import bde_pkg::*;

   logic      stable_ff, stable_in;
   logic      pending_ff, pending_in;
   stamp_type start_ff, start_in;
   logic      differ;
   logic      armed;
   stamp_type elapsed;
   logic      expired;
   logic      flip;

   // A differing sample with no timer running starts the timer at this poll.
   assign differ   = sample != stable_ff;
   assign armed    = pending_ff || differ;
   assign start_in = (!pending_ff && differ) ? now_ms : start_ff;

   // The stable bit flips once the elapsed time strictly exceeds the delay and the sample still differs.
   assign elapsed = now_ms - start_in;
   assign expired = elapsed > {{(TIME_BITS-DELAY_BITS){1'b0}}, debounce_ms};
   assign flip    = armed && expired && differ;

   assign stable_in  = stable_ff ^ flip;
   assign pending_in = armed && !flip;

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff  <= 1'b0;
         pending_ff <= 1'b0;
      end else if (enable) begin
         stable_ff  <= stable_in;
         pending_ff <= pending_in;
      end
   end

   // The timestamp is only read while the timer is pending.
   always_ff @(posedge clock) begin
      if (enable) begin
         start_ff <= start_in;
      end
   end

   assign status.stable_now  = stable_ff;
   assign status.stable_next = stable_in;

endmodule : bde_chan

`default_nettype wire
